@@ rtl/pcfs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcfs_pkg: shared types and constants of the periodic frame scheduler
// Table geometry, request codes and the entry record.
// ----------------------------------------------------------------------------
package pcfs_pkg;
	localparam int MAX_FRAMES = 16;
	localparam int TIME_BITS  = 32;
	localparam int IDX_BITS   = $clog2(MAX_FRAMES);
	localparam int CNT_BITS   = $clog2(MAX_FRAMES + 1);

	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_ADD    = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_ENABLE = 3'd3;
	localparam logic [2:0] REQ_WRITE  = 3'd4;

	// one table entry
	typedef struct packed {
		logic [28:0]          id;
		logic                 ext;
		logic [3:0]           len;
		logic [63:0]          data;
		logic [31:0]          period;
		logic [TIME_BITS-1:0] last;
		logic                 en;
	} entry_t;

	// request broadcast to every cell
	typedef struct packed {
		logic [2:0]           op;
		logic [28:0]          id;
		logic                 ext;
		logic [3:0]           len;
		logic [31:0]          period;
		logic                 en;
		logic [63:0]          data;
		logic [7:0]           mask;
		logic [TIME_BITS-1:0] now;
	} cmd_t;

	// cell control issued by the sequencer for one cycle
	typedef struct packed {
		logic apply;   // add/remove/enable/write takes effect this cycle
		logic rotate;  // tick scan: shift the row by one place
	} ctl_t;

	// stage status a cell passes to its right neighbor
	typedef struct packed {
		logic valid;   // this cell holds a live entry
		logic ins;     // new frame goes at or before this cell
	} link_t;
endpackage
`default_nettype wire

@@ rtl/periodic_can_frame_scheduler_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_can_frame_scheduler_core: periodic CAN transmit scheduler
// Sorted table of frames in a row of cells; ticks emit the frames due.
// ----------------------------------------------------------------------------
// The table is a row of MAX_FRAMES cells kept sorted by period. Add, remove,
// set-enable and write-data requests pass through two steps (accept, apply),
// and the next request is taken once the sequencer is back in idle. A tick
// rotates the row through the head cell, one entry a cycle, except while a due
// frame waits for the receiver to take the previous beat. The last due frame
// leaves from idle after the scan, once the output register is free; the next
// request is taken only while no beat is waiting. Results leave in table order
// and the last carries tlast.
// ----------------------------------------------------------------------------
module periodic_can_frame_scheduler_core (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// tdata: req_type[2:0], frame_id[31:3], id_extended[32], data_length[36:33],
	// period[68:37], enable_flag[69], payload[133:70], byte_mask[141:134]
	input  wire  [143:0] s_tdata,
	output logic         m_tvalid,
	input  wire          m_tready,
	// tdata: out_id[28:0], out_extended[29], out_length[33:30], out_payload[97:34]
	output logic [103:0] m_tdata,
	output logic         m_tlast
);
	import pcfs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_APPLY = 3'b010,
		ST_SCAN  = 3'b100
	} state_t;

	state_t st_q;
	cmd_t   cmd_q;
	ctl_t   ctl;
	logic [TIME_BITS-1:0] now_q;
	logic [IDX_BITS-1:0]  step_q;
	logic [CNT_BITS-1:0]  cnt_q;

	entry_t ent [MAX_FRAMES];
	entry_t stp [MAX_FRAMES];
	link_t  lnk [MAX_FRAMES];
	logic   hit [MAX_FRAMES];
	logic   due [MAX_FRAMES];
	logic   match_any, full, adv;
	logic   rml [MAX_FRAMES];
	logic   emit_mid, emit_last;

	// pending result, held until a later due frame or the end of the scan decides its tlast
	logic         pend_q;
	logic [97:0]  pend_d_q;

	assign full = (cnt_q == CNT_BITS'(MAX_FRAMES));

	always_comb begin
		match_any = 1'b0;
		for (int i = 0; i < MAX_FRAMES; i++) begin
			rml[i] = match_any;
			match_any = match_any | hit[i];
		end
	end

	// head cell feeds the scan; stalls while a due head frame meets a pending result and a busy output register
	assign adv = (st_q == ST_SCAN) && !(due[0] && pend_q && m_tvalid && !m_tready);
	assign ctl.rotate = adv;
	assign ctl.apply  = (st_q == ST_APPLY);
	assign s_tready   = (st_q == ST_IDLE) && !m_tvalid;

	// a later due frame pushes out the pending one; after the scan it goes with tlast
	assign emit_mid  = adv && due[0] && pend_q;
	assign emit_last = (st_q == ST_IDLE) && pend_q && (!m_tvalid || m_tready);

	genvar g;
	for (g = 0; g < MAX_FRAMES; g++) begin : g_row
		link_t  ll;
		entry_t le, re, si;
		logic   rv, siv;
		if (g == 0) begin : g_head
			// head sees an always-valid left neighbor so an empty row fills from here
			assign ll.valid = 1'b1;
			assign ll.ins   = 1'b0;
			assign le       = '0;
		end else begin : g_body
			assign ll = lnk[g-1];
			assign le = ent[g-1];
		end
		if (g == MAX_FRAMES - 1) begin : g_tail
			assign re  = '0;
			assign rv  = 1'b0;
			assign si  = stp[0];
			assign siv = lnk[0].valid;
		end else begin : g_inner
			assign re  = ent[g+1];
			assign rv  = lnk[g+1].valid;
			assign si  = ent[g+1];
			assign siv = lnk[g+1].valid;
		end
		pcfs_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd_q), .ctl(ctl),
			.match_any(match_any), .rm_left(rml[g]), .full(full),
			.left_e(le), .left_l(ll), .right_e(re), .right_v(rv),
			.scan_in(si), .scan_in_v(siv),
			.ent(ent[g]), .lnk(lnk[g]), .hit(hit[g]), .due(due[g]), .stamped(stp[g])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			now_q  <= '0;
			cnt_q  <= '0;
			step_q <= '0;
			pend_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (emit_mid || emit_last) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (emit_last) pend_q <= 1'b0;
					if (s_tvalid && s_tready) begin
						if (s_tdata[2:0] == REQ_TICK) begin
							now_q  <= now_q + 1'b1;
							step_q <= '0;
							st_q   <= ST_SCAN;
						end else begin
							st_q <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					if (cmd_q.op == REQ_ADD && !match_any && !full) cnt_q <= cnt_q + 1'b1;
					if (cmd_q.op == REQ_REMOVE && match_any) cnt_q <= cnt_q - 1'b1;
					st_q <= ST_IDLE;
				end
				ST_SCAN: if (adv) begin
					if (due[0]) pend_q <= 1'b1;
					step_q <= step_q + 1'b1;
					if (step_q == IDX_BITS'(MAX_FRAMES - 1)) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// output beat and pending frame data
	always_ff @(posedge clk) begin
		if (emit_mid || emit_last) begin
			m_tdata <= {6'd0, pend_d_q};
			m_tlast <= emit_last;
		end
		if (adv && due[0]) begin
			pend_d_q <= {ent[0].data, ent[0].len, ent[0].ext, ent[0].id};
		end
	end

	// captured request payload; now carries the time after a tick
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q.op     <= s_tdata[2:0];
			cmd_q.id     <= s_tdata[31:3];
			cmd_q.ext    <= s_tdata[32];
			cmd_q.len    <= s_tdata[36:33];
			cmd_q.period <= s_tdata[68:37];
			cmd_q.en     <= s_tdata[69];
			cmd_q.data   <= s_tdata[133:70];
			cmd_q.mask   <= s_tdata[141:134];
			cmd_q.now    <= now_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

@@ rtl/pcfs_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcfs_cell: one slot of the sorted frame table
// Holds one entry; shifts right on insert, left on remove, rotates on scan.
// ----------------------------------------------------------------------------
module pcfs_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pcfs_pkg::cmd_t       cmd,
	input  pcfs_pkg::ctl_t       ctl,
	input  wire                  match_any,  // id present somewhere in the row
	input  wire                  rm_left,    // removed id sits left of this cell
	input  wire                  full,
	input  pcfs_pkg::entry_t     left_e,
	input  pcfs_pkg::link_t      left_l,
	input  pcfs_pkg::entry_t     right_e,
	input  wire                  right_v,
	input  pcfs_pkg::entry_t     scan_in,    // entry rotating in during a tick
	input  wire                  scan_in_v,
	output pcfs_pkg::entry_t     ent,
	output pcfs_pkg::link_t      lnk,
	output logic                 hit,
	output logic                 due,
	output pcfs_pkg::entry_t     stamped     // this entry after a possible send
);
	import pcfs_pkg::*;

	entry_t e_q;
	logic   v_q;
	logic   gt;
	entry_t nw;

	assign ent = e_q;
	assign hit = v_q && (e_q.id == cmd.id);
	assign gt  = v_q && (e_q.period > cmd.period);
	assign lnk.valid = v_q;
	assign lnk.ins   = left_l.ins || gt || (!v_q && left_l.valid);
	assign due = v_q && e_q.en && ((cmd.now - e_q.last) >= TIME_BITS'(e_q.period));

	always_comb begin
		stamped = e_q;
		if (due) begin
			stamped.last = cmd.now;
		end
		nw = '0;
		nw.id = cmd.id;
		nw.ext = cmd.ext;
		nw.len = cmd.len;
		nw.period = cmd.period;
		nw.en = 1'b1;
	end

	// valid bits: an add fills only the first empty cell of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctl.rotate) begin
			v_q <= scan_in_v;
		end else if (ctl.apply) begin
			case (cmd.op)
				REQ_ADD: if (!match_any && !full && !v_q && left_l.valid) v_q <= 1'b1;
				REQ_REMOVE: if (match_any && (rm_left || hit)) v_q <= right_v;
				default: ;
			endcase
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			e_q <= scan_in;
		end else if (ctl.apply) begin
			case (cmd.op)
				REQ_ADD: if (!match_any && !full) begin
					if (left_l.ins) e_q <= left_e;
					else if (lnk.ins) e_q <= nw;
				end
				REQ_REMOVE: if (match_any && (rm_left || hit)) e_q <= right_e;
				REQ_ENABLE: if (hit) e_q.en <= cmd.en;
				REQ_WRITE: if (hit) begin
					for (int k = 0; k < 8; k++) begin
						if (cmd.mask[k]) e_q.data[8*k +: 8] <= cmd.data[8*k +: 8];
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the periodic CAN frame scheduler core
// Drives request beats on the slave stream, predicts the frames each tick
// should emit from a shadow copy of the frame table, and checks every output
// beat in order. Directed cases come first, then random sequences under
// several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import pcfs_pkg::*;

	// predicted output beat
	typedef struct {
		logic [28:0] id;
		logic        ext;
		logic [3:0]  len;
		logic [63:0] data;
		logic        last;
	} frame_beat_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic         m_tlast;

	// shadow frame table
	logic [28:0]          tbl_id     [MAX_FRAMES];
	logic                 tbl_ext    [MAX_FRAMES];
	logic [3:0]           tbl_len    [MAX_FRAMES];
	logic [63:0]          tbl_data   [MAX_FRAMES];
	logic [31:0]          tbl_period [MAX_FRAMES];
	logic [TIME_BITS-1:0] tbl_last   [MAX_FRAMES];
	logic                 tbl_en     [MAX_FRAMES];
	int                   tbl_count;
	logic [TIME_BITS-1:0] sched_time;

	frame_beat_t due_frames[$];
	int          fail_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	periodic_can_frame_scheduler_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// index of id in the shadow table, -1 if absent
	function automatic int find_frame(input logic [28:0] id);
		for (int i = 0; i < tbl_count; i++)
			if (tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	// apply one request to the shadow table and queue the frames it emits
	task automatic predict_request(input logic [2:0] op, input logic [28:0] id,
			input logic ext, input logic [3:0] len, input logic [31:0] per,
			input logic en, input logic [63:0] data, input logic [7:0] mask);
		int pos;
		int idx;
		int first;
		frame_beat_t b;
		logic [63:0] sel;
		idx = find_frame(id);
		case (op)
			REQ_TICK: begin
				sched_time = sched_time + 1'b1;
				first = due_frames.size();
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_en[i] && (sched_time - tbl_last[i]) >= tbl_period[i]) begin
						tbl_last[i] = sched_time;
						b.id = tbl_id[i];
						b.ext = tbl_ext[i];
						b.len = tbl_len[i];
						b.data = tbl_data[i];
						b.last = 1'b0;
						due_frames.push_back(b);
					end
				end
				if (due_frames.size() > first)
					due_frames[due_frames.size()-1].last = 1'b1;
			end
			REQ_ADD: begin
				if (idx < 0 && tbl_count < MAX_FRAMES) begin
					pos = tbl_count;
					for (int i = 0; i < tbl_count; i++)
						if (tbl_period[i] > per) begin
							pos = i;
							break;
						end
					for (int i = tbl_count; i > pos; i--) begin
						tbl_id[i] = tbl_id[i-1];
						tbl_ext[i] = tbl_ext[i-1];
						tbl_len[i] = tbl_len[i-1];
						tbl_data[i] = tbl_data[i-1];
						tbl_period[i] = tbl_period[i-1];
						tbl_last[i] = tbl_last[i-1];
						tbl_en[i] = tbl_en[i-1];
					end
					tbl_id[pos] = id;
					tbl_ext[pos] = ext;
					tbl_len[pos] = len;
					tbl_data[pos] = '0;
					tbl_period[pos] = per;
					tbl_last[pos] = '0;
					tbl_en[pos] = 1'b1;
					tbl_count++;
				end
			end
			REQ_REMOVE: begin
				if (idx >= 0) begin
					for (int i = idx; i + 1 < tbl_count; i++) begin
						tbl_id[i] = tbl_id[i+1];
						tbl_ext[i] = tbl_ext[i+1];
						tbl_len[i] = tbl_len[i+1];
						tbl_data[i] = tbl_data[i+1];
						tbl_period[i] = tbl_period[i+1];
						tbl_last[i] = tbl_last[i+1];
						tbl_en[i] = tbl_en[i+1];
					end
					tbl_count--;
				end
			end
			REQ_ENABLE: begin
				if (idx >= 0)
					tbl_en[idx] = en;
			end
			REQ_WRITE: begin
				if (idx >= 0) begin
					for (int k = 0; k < 8; k++)
						sel[8*k +: 8] = {8{mask[k]}};
					tbl_data[idx] = (tbl_data[idx] & ~sel) | (data & sel);
				end
			end
			default: ;
		endcase
	endtask

	// send one request beat, then update the prediction
	task automatic send_request(input logic [2:0] op, input logic [28:0] id,
			input logic ext, input logic [3:0] len, input logic [31:0] per,
			input logic en, input logic [63:0] data, input logic [7:0] mask);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, mask, data, en, per, len, ext, id, op};
		// tready only moves at rising edges, so look at it between them
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		predict_request(op, id, ext, len, per, en, data, mask);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_tick();
		send_request(REQ_TICK, 29'($urandom), 1'($urandom), 4'($urandom), $urandom,
			1'($urandom), {$urandom, $urandom}, 8'($urandom));
	endtask

	task automatic send_add(input logic [28:0] id, input logic [31:0] per);
		send_request(REQ_ADD, id, 1'($urandom), 4'($urandom), per, 1'($urandom),
			{$urandom, $urandom}, 8'($urandom));
	endtask

	// wait until all predicted frames are out, then let the block settle
	task automatic drain_frames();
		while (due_frames.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// receiver stall pattern
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// output checker
	always @(posedge clk) begin
		frame_beat_t b;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_frames.size() == 0) begin
				$error("unexpected frame beat id %h", m_tdata[28:0]);
				fail_count++;
			end else begin
				b = due_frames.pop_front();
				if (m_tdata[28:0] !== b.id) begin
					$error("out_id expected %h actual %h", b.id, m_tdata[28:0]);
					fail_count++;
				end
				if (m_tdata[29] !== b.ext) begin
					$error("out_extended expected %h actual %h", b.ext, m_tdata[29]);
					fail_count++;
				end
				if (m_tdata[33:30] !== b.len) begin
					$error("out_length expected %h actual %h", b.len, m_tdata[33:30]);
					fail_count++;
				end
				if (m_tdata[97:34] !== b.data) begin
					$error("out_payload expected %h actual %h", b.data, m_tdata[97:34]);
					fail_count++;
				end
				if (m_tlast !== b.last) begin
					$error("last_of_run expected %h actual %h", b.last, m_tlast);
					fail_count++;
				end
			end
		end
	end

	// extremes, every request code, duplicates, full table, unknown ids
	task automatic test_directed();
		send_tick();
		send_add(29'h1FFFFFFF, 32'd0);
		send_request(REQ_ADD, 29'h0, 1'b1, 4'd15, 32'd1, 1'b0, '1, '1);
		send_request(REQ_ADD, 29'h0, 1'b0, 4'd8, 32'd5, 1'b0, '0, '0);
		send_request(REQ_ADD, 29'h123, 1'b0, 4'd9, 32'd1, 1'b0, '0, '0);
		send_request(REQ_WRITE, 29'h0, 1'b0, 4'd0, 32'd0, 1'b0, '1, 8'hFF);
		send_request(REQ_WRITE, 29'h123, 1'b0, 4'd0, 32'd0, 1'b0,
			64'h0123456789ABCDEF, 8'hA5);
		send_request(REQ_WRITE, 29'h777, 1'b0, 4'd0, 32'd0, 1'b0, '1, 8'hFF);
		send_tick();
		send_request(REQ_ENABLE, 29'h123, 1'b0, 4'd0, 32'd0, 1'b0, '0, '0);
		send_request(REQ_ENABLE, 29'h555, 1'b0, 4'd0, 32'd0, 1'b1, '0, '0);
		send_tick();
		send_request(REQ_ENABLE, 29'h123, 1'b0, 4'd0, 32'd0, 1'b1, '0, '0);
		send_request(3'd5, 29'h0, 1'b0, 4'd0, 32'd0, 1'b0, '0, '0);
		send_request(3'd7, 29'h123, 1'b1, 4'd0, 32'd0, 1'b0, '1, '1);
		send_add(29'h40, 32'hFFFFFFFF);
		send_request(REQ_REMOVE, 29'h1FFFFFFF, 1'b0, 4'd0, 32'd0, 1'b0, '0, '0);
		send_request(REQ_REMOVE, 29'h999, 1'b0, 4'd0, 32'd0, 1'b0, '0, '0);
		for (int i = 0; i < 15; i++)
			send_add(29'('h200 + i), $urandom_range(3));
		send_tick();
		send_tick();
		drain_frames();
		for (int i = 0; i < 17; i++)
			send_request(REQ_REMOVE, 29'('h200 + i), 1'b0, 4'd0, 32'd0, 1'b0, '0, '0);
	endtask

	// random sequences with a small id pool so requests hit live frames
	task automatic test_random(input int count);
		int r;
		logic [28:0] id;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			id = ($urandom_range(3) == 0) ? 29'($urandom) : 29'($urandom_range(23));
			if (r < 40)
				send_tick();
			else if (r < 60)
				send_request(REQ_ADD, id, 1'($urandom), 4'($urandom),
					($urandom_range(9) == 0) ? $urandom : $urandom_range(6),
					1'($urandom), {$urandom, $urandom}, 8'($urandom));
			else if (r < 70)
				send_request(REQ_REMOVE, id, 1'($urandom), 4'($urandom), $urandom,
					1'($urandom), {$urandom, $urandom}, 8'($urandom));
			else if (r < 80)
				send_request(REQ_ENABLE, id, 1'($urandom), 4'($urandom), $urandom,
					1'($urandom), {$urandom, $urandom}, 8'($urandom));
			else if (r < 96)
				send_request(REQ_WRITE, id, 1'($urandom), 4'($urandom), $urandom,
					1'($urandom), {$urandom, $urandom}, 8'($urandom));
			else
				send_request(3'($urandom_range(7, 5)), id, 1'($urandom), 4'($urandom),
					$urandom, 1'($urandom), {$urandom, $urandom}, 8'($urandom));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		fail_count = 0;
		tbl_count = 0;
		sched_time = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(100);
		send_idle_pct = 47;
		test_random(100);
		send_idle_pct = 0;
		recv_stall_pct = 47;
		test_random(100);
		send_idle_pct = 16;
		recv_stall_pct = 16;
		test_random(100);
		drain_frames();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// run time limit
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/pcfs_pkg.sv
rtl/pcfs_cell.sv
rtl/periodic_can_frame_scheduler_core.sv
verif/tb_top.sv
